FILE: rtl/vcp_pkg.sv
package vcp_pkg;

  // input and matrix formats
  localparam int VERT_W = 32;
  localparam int COEF_W = 16;
  localparam int PROD_W = COEF_W + VERT_W;
  // four products summed, two more bits of headroom
  localparam int CLIP_W = PROD_W + 2;

  // depth fraction: 32 fraction bits plus the integer bit for 1.0
  localparam int DEPTH_FRAC = 32;
  localparam int DEPTH_QW = DEPTH_FRAC + 1;

  localparam int SCREEN_DIM_MAX_DEF = 4096;

  // register indexes
  localparam logic [3:0] REG_MATRIX_ROW0 = 4'd0;
  localparam logic [3:0] REG_MATRIX_ROW1 = 4'd1;
  localparam logic [3:0] REG_MATRIX_ROW2 = 4'd2;
  localparam logic [3:0] REG_MATRIX_ROW3 = 4'd3;
  localparam logic [3:0] REG_VP_ORIGIN = 4'd4;
  localparam logic [3:0] REG_VP_SIZE = 4'd5;
  localparam logic [3:0] REG_SCREEN_H = 4'd6;
  localparam logic [3:0] REG_DEPTH_RANGE = 4'd7;

  // reset values
  localparam logic [63:0] RST_MATRIX_ROW0 = 64'h0000_0000_0000_0400;
  localparam logic [63:0] RST_MATRIX_ROW1 = 64'h0000_0000_0400_0000;
  localparam logic [63:0] RST_MATRIX_ROW2 = 64'h0000_0400_0000_0000;
  localparam logic [63:0] RST_MATRIX_ROW3 = 64'h0400_0000_0000_0000;
  localparam logic [23:0] RST_VP_ORIGIN = 24'd0;
  localparam logic [25:0] RST_VP_SIZE = 26'd3932800;
  localparam logic [12:0] RST_SCREEN_H = 13'd480;
  localparam logic [31:0] RST_DEPTH_RANGE = 32'hFFFF_0000;

endpackage

FILE: rtl/vcp_xform.sv
module vcp_xform
  import vcp_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [3:0][63:0]              rows_i,
  input  logic signed [VERT_W-1:0]      vx_i,
  input  logic signed [VERT_W-1:0]      vy_i,
  input  logic signed [VERT_W-1:0]      vz_i,
  output logic [3:0][CLIP_W-1:0]        clip_o
);

  logic signed [PROD_W-1:0] prod_q [4][4];
  logic [3:0][CLIP_W-1:0] clip_q;

  // stage 1: twelve products, w term is a shift
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        prod_q[r][0] <= PROD_W'($signed(rows_i[r][15:0])) * PROD_W'(vx_i);
        prod_q[r][1] <= PROD_W'($signed(rows_i[r][31:16])) * PROD_W'(vy_i);
        prod_q[r][2] <= PROD_W'($signed(rows_i[r][47:32])) * PROD_W'(vz_i);
        prod_q[r][3] <= PROD_W'($signed(rows_i[r][63:48])) <<< 16;
      end
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        clip_q[r] <= CLIP_W'(prod_q[r][0]) + CLIP_W'(prod_q[r][1])
                   + CLIP_W'(prod_q[r][2]) + CLIP_W'(prod_q[r][3]);
      end
    end
  end

  assign clip_o = clip_q;

endmodule

FILE: rtl/vcp_div.sv
module vcp_div #(
  parameter int WN  = 64,
  parameter int WD  = 32,
  parameter int WQ  = 16,
  parameter int LAT = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [WN-1:0] num_i,
  input  logic [WD-1:0] den_i,
  output logic [WQ-1:0] quo_o
);

  logic [WN-1:0] rem_q [LAT];
  logic [WD-1:0] den_q [LAT];
  logic [WQ-1:0] quo_q [LAT];

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < LAT; k++) begin : g_stage
    localparam int S = LAT - 1 - k;
    logic [WN-1:0] rem_in, rem_d;
    logic [WD-1:0] den_in;
    logic [WQ-1:0] quo_in, quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    if (S < WQ) begin : g_bit
      logic [WN:0] dsh;
      logic        ge;
      assign dsh   = (WN+1)'(den_in) << S;
      assign ge    = {1'b0, rem_in} >= dsh;
      assign rem_d = ge ? rem_in - dsh[WN-1:0] : rem_in;
      assign quo_d = (quo_in << 1) | WQ'(ge);
    end else begin : g_pass
      // quotient bit above the result width is known zero
      assign rem_d = rem_in;
      assign quo_d = quo_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[LAT-1];

endmodule

FILE: rtl/vertex_clip_project_viewport.sv
// Vertex clip, perspective divide and viewport mapping. One eye-space vertex
// (x, y, z in signed Q16.16, w = 1) is transformed by a programmable 4x4
// matrix of signed Q6.10 coefficients, dropped when clip w is not positive
// or the point lies outside -w..w on any axis, and otherwise mapped to a
// pixel (y flipped to top-left origin, clamped inside the viewport), a
// depth-buffer address and a Q0.16 depth between near and far. Dropped
// vertices give no output transfer. Throughput is one vertex per clock
// while vert_stall_o is low. A vertex passes 41 register stages, most of
// them in the 33-stage restoring divider that forms the 33-bit depth
// fraction (the x and y divides run beside it in the same stages). Two
// multiply stages, a clip stage, two axis-scaling stages, two output
// stages and the output register make up the rest. A two-entry output
// buffer decouples the sides: vert_stall_o is registered and only rises
// when a result is parked behind a stalled output. Registers must be
// written only while the pipeline is empty.
module vertex_clip_project_viewport
  import vcp_pkg::*;
#(
  parameter int SCREEN_DIM_MAX = SCREEN_DIM_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic [3:0]               cfg_index_i,
  input  logic [63:0]              cfg_wdata_i,
  // vertex input
  input  logic                     vert_valid_i,
  output logic                     vert_stall_o,
  input  logic signed [VERT_W-1:0] vert_x_i,
  input  logic signed [VERT_W-1:0] vert_y_i,
  input  logic signed [VERT_W-1:0] vert_z_i,
  // pixel output
  output logic                     pix_valid_o,
  input  logic                     pix_stall_i,
  output logic [11:0]              pixel_x_o,
  output logic [11:0]              pixel_y_o,
  output logic [23:0]              depth_index_o,
  output logic [15:0]              depth_value_o
);

  localparam int DW   = $clog2(SCREEN_DIM_MAX + 1);  // viewport dimension width
  localparam int NW   = CLIP_W + 1;                   // c + w and 2w
  localparam int LO_W = 26;                           // low slice of c + w in the axis product
  localparam int HI_W = NW - LO_W;
  localparam int PW   = NW + DW;                      // dim * (c + w)
  localparam int ZW   = NW + DEPTH_FRAC;              // (z + w) << 32
  localparam int LAT  = DEPTH_QW;
  localparam int MW   = (DW > 12) ? DW : 12;
  localparam int PXW  = MW + 1;
  localparam int PYW  = MW + 2;
  localparam int IW   = (2 * DW + 1 > 24) ? 2 * DW + 1 : 24;
  localparam int PRW  = 17 + DEPTH_QW + 1;            // span * fraction
  localparam int NV   = 2 + LAT;                      // valid line across s4, s5, divider

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] depth_index;
    logic [15:0] depth_value;
  } pix_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [3:0][63:0] mat_q;
  logic [23:0]      vp_origin_q;
  logic [25:0]      vp_size_q;
  logic [12:0]      screen_h_q;
  logic [31:0]      depth_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0]      <= RST_MATRIX_ROW0;
      mat_q[1]      <= RST_MATRIX_ROW1;
      mat_q[2]      <= RST_MATRIX_ROW2;
      mat_q[3]      <= RST_MATRIX_ROW3;
      vp_origin_q   <= RST_VP_ORIGIN;
      vp_size_q     <= RST_VP_SIZE;
      screen_h_q    <= RST_SCREEN_H;
      depth_range_q <= RST_DEPTH_RANGE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MATRIX_ROW0: mat_q[0]      <= cfg_wdata_i;
        REG_MATRIX_ROW1: mat_q[1]      <= cfg_wdata_i;
        REG_MATRIX_ROW2: mat_q[2]      <= cfg_wdata_i;
        REG_MATRIX_ROW3: mat_q[3]      <= cfg_wdata_i;
        REG_VP_ORIGIN:   vp_origin_q   <= cfg_wdata_i[23:0];
        REG_VP_SIZE:     vp_size_q     <= cfg_wdata_i[25:0];
        REG_SCREEN_H:    screen_h_q    <= cfg_wdata_i[12:0];
        REG_DEPTH_RANGE: depth_range_q <= cfg_wdata_i[31:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // dimensions: zero acts as one, oversized saturates
  logic [DW-1:0] vw, vh, hgt;
  logic [12:0]   vw_f, vh_f;
  assign vw_f = vp_size_q[12:0];
  assign vh_f = vp_size_q[25:13];

  assign vw  = (vw_f == '0) ? DW'(1) :
               (32'(vw_f) > SCREEN_DIM_MAX) ? DW'(SCREEN_DIM_MAX) : DW'(vw_f);
  assign vh  = (vh_f == '0) ? DW'(1) :
               (32'(vh_f) > SCREEN_DIM_MAX) ? DW'(SCREEN_DIM_MAX) : DW'(vh_f);
  assign hgt = (screen_h_q == '0) ? DW'(1) :
               (32'(screen_h_q) > SCREEN_DIM_MAX) ? DW'(SCREEN_DIM_MAX) : DW'(screen_h_q);

  logic [11:0] x0, y0;
  logic [15:0] dr_near, dr_far;
  assign x0      = vp_origin_q[11:0];
  assign y0      = vp_origin_q[23:12];
  assign dr_near = depth_range_q[15:0];
  assign dr_far  = depth_range_q[31:16];

  // ---------------------------------------------------------------------------
  // pipeline enable: the whole pipe advances unless a result is parked
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_vld_q;
  assign en           = !skid_vld_q;
  assign vert_stall_o = skid_vld_q;

  // s1, s2: matrix multiply
  logic v1_q, v2_q;
  logic [3:0][CLIP_W-1:0] clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= vert_valid_i;
      v2_q <= v1_q;
    end
  end

  vcp_xform u_xform (
    .clk_i  (clk_i),
    .en_i   (en),
    .rows_i (mat_q),
    .vx_i   (vert_x_i),
    .vy_i   (vert_y_i),
    .vz_i   (vert_z_i),
    .clip_o (clip)
  );

  // ---------------------------------------------------------------------------
  // s3: clip test, offsets into 0..2w
  // ---------------------------------------------------------------------------
  logic signed [CLIP_W-1:0] cx, cy, cz, cw;
  logic                     keep;
  assign cx = $signed(clip[0]);
  assign cy = $signed(clip[1]);
  assign cz = $signed(clip[2]);
  assign cw = $signed(clip[3]);

  assign keep = (cw > 0)
             && (cx >= -cw) && (cx <= cw)
             && (cy >= -cw) && (cy <= cw)
             && (cz >= -cw) && (cz <= cw);

  logic          v3_q;
  logic [NW-1:0] nx3_q, ny3_q, nz3_q, den3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx3_q  <= NW'(cx) + NW'(cw);
      ny3_q  <= NW'(cy) + NW'(cw);
      nz3_q  <= NW'(cz) + NW'(cw);
      den3_q <= NW'(cw) + NW'(cw);
    end
  end

  // ---------------------------------------------------------------------------
  // s4, s5: dim * (c + w) as two partial products, then summed
  // ---------------------------------------------------------------------------
  logic [LO_W+DW-1:0] plo_x4_q, plo_y4_q;
  logic [HI_W+DW-1:0] phi_x4_q, phi_y4_q;
  logic [NW-1:0]      nz4_q, den4_q;
  logic [PW-1:0]      px5_q, py5_q;
  logic [ZW-1:0]      nz5_q;
  logic [NW-1:0]      den5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_x4_q <= (LO_W+DW)'(nx3_q[LO_W-1:0]) * (LO_W+DW)'(vw);
      phi_x4_q <= (HI_W+DW)'(nx3_q[NW-1:LO_W]) * (HI_W+DW)'(vw);
      plo_y4_q <= (LO_W+DW)'(ny3_q[LO_W-1:0]) * (LO_W+DW)'(vh);
      phi_y4_q <= (HI_W+DW)'(ny3_q[NW-1:LO_W]) * (HI_W+DW)'(vh);
      nz4_q    <= nz3_q;
      den4_q   <= den3_q;

      px5_q  <= (PW'(phi_x4_q) << LO_W) + PW'(plo_x4_q);
      py5_q  <= (PW'(phi_y4_q) << LO_W) + PW'(plo_y4_q);
      nz5_q  <= {nz4_q, DEPTH_FRAC'(0)};
      den5_q <= den4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // dividers: pixel offsets and the depth fraction, all the same latency
  // ---------------------------------------------------------------------------
  logic [DW-1:0]       qx, qy;
  logic [DEPTH_QW-1:0] qz;

  vcp_div #(.WN(PW), .WD(NW), .WQ(DW), .LAT(LAT)) u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i (px5_q), .den_i (den5_q), .quo_o (qx)
  );

  vcp_div #(.WN(PW), .WD(NW), .WQ(DW), .LAT(LAT)) u_div_y (
    .clk_i (clk_i), .en_i (en), .num_i (py5_q), .den_i (den5_q), .quo_o (qy)
  );

  vcp_div #(.WN(ZW), .WD(NW), .WQ(DEPTH_QW), .LAT(LAT)) u_div_z (
    .clk_i (clk_i), .en_i (en), .num_i (nz5_q), .den_i (den5_q), .quo_o (qz)
  );

  // valid line across s4, s5 and the divider stages
  logic [NV-1:0] vpipe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpipe_q <= '0;
    end else if (en) begin
      vpipe_q <= {vpipe_q[NV-2:0], v3_q};
    end
  end

  // ---------------------------------------------------------------------------
  // sA: clamp to the viewport, pixel coordinates, depth product
  // ---------------------------------------------------------------------------
  logic [DW-1:0]         rx, ry, vw_m1, vh_m1;
  logic [PXW-1:0]        px_sum;
  logic signed [PYW-1:0] py_sum;
  logic signed [16:0]    dspan;

  assign vw_m1  = vw - DW'(1);
  assign vh_m1  = vh - DW'(1);
  // far edge lands one past the last column or row
  assign rx     = (qx > vw_m1) ? vw_m1 : qx;
  assign ry     = (qy > vh_m1) ? vh_m1 : qy;
  assign px_sum = PXW'(x0) + PXW'(rx);
  assign py_sum = $signed(PYW'(hgt)) - $signed(PYW'(1))
                - $signed(PYW'(y0)) - $signed(PYW'(ry));
  assign dspan  = $signed({1'b0, dr_far}) - $signed({1'b0, dr_near});

  logic                  va_q;
  logic [DW-1:0]         rx_a_q, rinv_a_q;
  logic [11:0]           px_a_q, py_a_q;
  logic signed [PRW-1:0] prod_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= vpipe_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_a_q   <= rx;
      rinv_a_q <= vh_m1 - ry;
      px_a_q   <= (px_sum > PXW'(4095)) ? 12'hFFF : px_sum[11:0];
      if (py_sum < 0) begin
        py_a_q <= '0;
      end else if (py_sum > $signed(PYW'(4095))) begin
        py_a_q <= 12'hFFF;
      end else begin
        py_a_q <= py_sum[11:0];
      end
      prod_a_q <= PRW'(dspan) * $signed(PRW'(qz));
    end
  end

  // ---------------------------------------------------------------------------
  // sB: depth-buffer address and rounded depth
  // ---------------------------------------------------------------------------
  logic [IW-1:0]         idx_full;
  logic signed [PRW-1:0] prod_rnd;
  logic signed [19:0]    dsum;

  assign idx_full = IW'(rinv_a_q) * IW'(vw) + IW'(rx_a_q);
  // round half up, then drop the 32 fraction bits
  assign prod_rnd = (prod_a_q + $signed(PRW'(64'h8000_0000))) >>> DEPTH_FRAC;
  assign dsum     = $signed({4'b0, dr_near}) + prod_rnd[19:0];

  logic vb_q;
  pix_t pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q.pixel_x     <= px_a_q;
      pb_q.pixel_y     <= py_a_q;
      pb_q.depth_index <= idx_full[23:0];
      if (dsum < 0) begin
        pb_q.depth_value <= '0;
      end else if (dsum > $signed(20'd65535)) begin
        pb_q.depth_value <= 16'hFFFF;
      end else begin
        pb_q.depth_value <= dsum[15:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register with a skid entry behind it
  // ---------------------------------------------------------------------------
  logic out_vld_q;
  pix_t out_q, skid_q;
  logic take;

  assign take = out_vld_q && !pix_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (out_vld_q && !take) begin
      // output blocked: park a new result
      if (vb_q) begin
        skid_vld_q <= 1'b1;
      end
    end else begin
      out_vld_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (out_vld_q && !take) begin
      skid_q <= pb_q;
    end else begin
      out_q <= pb_q;
    end
  end

  assign pix_valid_o   = out_vld_q;
  assign pixel_x_o     = out_q.pixel_x;
  assign pixel_y_o     = out_q.pixel_y;
  assign depth_index_o = out_q.depth_index;
  assign depth_value_o = out_q.depth_value;

endmodule

FILE: tb/sv/vertex_clip_project_viewport_tb.sv
`timescale 1ns / 100ps

module vertex_clip_project_viewport_tb;
  import vcp_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 1000000;
  // input transfer to output register, plus margin for the output buffer
  localparam int PIPE_DRAIN = 60;
  localparam logic [3:0] REG_INDEX_UNUSED = 4'd9;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] depth_index;
    logic [15:0] depth_value;
  } pixel_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_index_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic vert_valid_i = 1'b0;
  logic vert_stall_o;
  logic signed [VERT_W-1:0] vert_x_i = '0;
  logic signed [VERT_W-1:0] vert_y_i = '0;
  logic signed [VERT_W-1:0] vert_z_i = '0;
  logic pix_valid_o;
  logic pix_stall_i = 1'b0;
  logic [11:0] pixel_x_o;
  logic [11:0] pixel_y_o;
  logic [23:0] depth_index_o;
  logic [15:0] depth_value_o;

  // shadow copy of the block registers
  logic [63:0] mat_row [4];
  logic [23:0] vp_origin;
  logic [25:0] vp_size;
  logic [12:0] scr_height;
  logic [31:0] z_range;

  pixel_result_t pending_pixels[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit idle_en = 1'b1;
  int unsigned hold_len = 0;
  bit hold_go = 1'b0;

  vertex_clip_project_viewport uut (.*);

  always #HALF_PERIOD clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver side: random stall bursts, plus one long hold-off on request
  always @(posedge clk_i) begin
    static int unsigned burst_left = 0;
    static int unsigned hold_left = 0;
    static bit hold_seen = 1'b0;
    logic nxt;
    nxt = 1'b0;
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      nxt = 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 17);
      nxt = 1'b1;
    end
    pix_stall_i <= nxt;
  end

  // result checker; outputs and stall are stable at the falling edge,
  // so a transfer seen here happens at the next rising edge
  always @(negedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && pix_valid_o && !pix_stall_i) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel transfer x=%0d y=%0d idx=%0d z=%0h",
                   pixel_x_o, pixel_y_o, depth_index_o, depth_value_o);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x_o !== want.pixel_x || pixel_y_o !== want.pixel_y ||
            depth_index_o !== want.depth_index ||
            depth_value_o !== want.depth_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch: expected x=%0d y=%0d idx=%0d z=%0h, ",
                      "got x=%0d y=%0d idx=%0d z=%0h"},
                     want.pixel_x, want.pixel_y, want.depth_index, want.depth_value,
                     pixel_x_o, pixel_y_o, depth_index_o, depth_value_o);
        end
      end
    end
  end

  function automatic bit [63:0] clamp_dim(bit [63:0] d);
    if (d == 0) return 1;
    if (d > SCREEN_DIM_MAX_DEF) return SCREEN_DIM_MAX_DEF;
    return d;
  endfunction

  // floor(dim * (c + w) / 2w), clamped to the last column or row
  function automatic bit [63:0] scale_axis(longint c, longint w, bit [63:0] dim);
    bit [63:0] num;
    bit [63:0] den;
    bit [63:0] r;
    num = c + w;
    den = 2 * w;
    r = (num * dim) / den;
    if (r > dim - 1) r = dim - 1;
    return r;
  endfunction

  // (c + w) / 2w as unsigned Q1.32, truncated
  function automatic bit [63:0] depth_fraction(longint c, longint w);
    bit [63:0] num;
    bit [63:0] den;
    bit [63:0] q;
    num = c + w;
    den = 2 * w;
    q = 0;
    if (num >= den) return 64'd1 << 32;
    for (int i = 0; i < 32; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  // transform, clip and viewport map; returns 0 when the vertex is dropped
  function automatic bit project_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        output pixel_result_t res);
    longint v [4];
    longint c [4];
    longint w, py, nr, fr, d, prod;
    bit [63:0] vw, vh, hgt, x0, y0, rx, ry, px, q, biased;
    v[0] = longint'(signed'(x));
    v[1] = longint'(signed'(y));
    v[2] = longint'(signed'(z));
    v[3] = 65536;
    res = '0;
    for (int r = 0; r < 4; r++) begin
      c[r] = 0;
      for (int j = 0; j < 4; j++)
        c[r] += longint'(signed'(mat_row[r][16*j +: 16])) * v[j];
    end
    w = c[3];
    if (w <= 0) return 1'b0;
    for (int r = 0; r < 3; r++)
      if (c[r] < -w || c[r] > w) return 1'b0;
    vw = clamp_dim(vp_size[12:0]);
    vh = clamp_dim(vp_size[25:13]);
    hgt = clamp_dim(scr_height);
    x0 = vp_origin[11:0];
    y0 = vp_origin[23:12];
    rx = scale_axis(c[0], w, vw);
    ry = scale_axis(c[1], w, vh);
    px = x0 + rx;
    if (px > 4095) px = 4095;
    py = longint'(hgt) - 1 - longint'(y0 + ry);
    if (py < 0) py = 0;
    if (py > 4095) py = 4095;
    q = depth_fraction(c[2], w);
    nr = z_range[15:0];
    fr = z_range[31:16];
    prod = (fr - nr) * longint'(q);
    biased = prod + (64'd65536 << 32) + (64'd1 << 31);
    d = nr + longint'(biased >> 32) - 65536;
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    res.pixel_x = px[11:0];
    res.pixel_y = py[11:0];
    res.depth_index = 24'(((vh - 1 - ry) * vw) + rx);
    res.depth_value = d[15:0];
    return 1'b1;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_MATRIX_ROW0: mat_row[0] = data;
      REG_MATRIX_ROW1: mat_row[1] = data;
      REG_MATRIX_ROW2: mat_row[2] = data;
      REG_MATRIX_ROW3: mat_row[3] = data;
      REG_VP_ORIGIN: vp_origin = data[23:0];
      REG_VP_SIZE: vp_size = data[25:0];
      REG_SCREEN_H: scr_height = data[12:0];
      REG_DEPTH_RANGE: z_range = data[31:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for every expected pixel, then let dropped vertices leave the pipe
  task automatic drain_pipeline();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // offer one vertex and return after its transfer edge; valid stays high
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pixel_result_t res;
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      vert_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vert_valid_i <= 1'b1;
    vert_x_i <= x;
    vert_y_i <= y;
    vert_z_i <= z;
    forever begin
      @(negedge clk_i);
      if (!vert_stall_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    if (project_vertex(x, y, z, res)) pending_pixels.insert(pending_pixels.size(), res);
  endtask

  task automatic end_burst();
    vert_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] pack_row(logic [15:0] c0, logic [15:0] c1,
                                           logic [15:0] c2, logic [15:0] c3);
    return {c3, c2, c1, c0};
  endfunction

  // random coordinate with |value| <= lim, sometimes exactly on the edge
  function automatic logic [31:0] coord_within(longint lim);
    longint mag;
    if (lim > 64'sh7FFFFFFF) lim = 64'sh7FFFFFFF;
    if ($urandom_range(0, 15) == 0) mag = lim;
    else mag = longint'($urandom) % (lim + 1);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // reset values, far edges, clip boundary and the largest field values
  task automatic test_directed_defaults();
    send_vertex(32'd0, 32'd0, 32'd0);
    send_vertex(32'sd65536, 32'sd65536, 32'sd65536);
    send_vertex(-32'sd65536, -32'sd65536, -32'sd65536);
    send_vertex(32'sd65537, 32'd0, 32'd0);
    send_vertex(32'd0, -32'sd65537, 32'd0);
    send_vertex(32'd0, 32'd0, 32'sd65537);
    send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vertex(32'sh0000FFFF, -32'sh0000FFFF, 32'sh00008000);
    end_burst();
    drain_pipeline();
  endtask

  // non-positive w, degenerate viewport and screen sizes, saturated pixels
  task automatic test_directed_corners();
    write_reg(REG_MATRIX_ROW3, '0);
    send_vertex(32'd0, 32'd0, 32'd0);
    end_burst();
    drain_pipeline();
    write_reg(REG_MATRIX_ROW3, pack_row(16'd0, 16'd0, 16'd0, 16'hFC00));
    send_vertex(32'd0, 32'd0, 32'd0);
    end_burst();
    drain_pipeline();
    write_reg(REG_MATRIX_ROW3, RST_MATRIX_ROW3);
    write_reg(REG_VP_SIZE, '0);
    write_reg(REG_SCREEN_H, '0);
    write_reg(REG_VP_ORIGIN, 24'hFFFFFF);
    write_reg(REG_DEPTH_RANGE, 32'h0000FFFF);
    send_vertex(32'sd65536, 32'sd65536, 32'sd65536);
    send_vertex(-32'sd65536, -32'sd65536, -32'sd65536);
    send_vertex(32'd0, 32'd0, 32'd0);
    end_burst();
    drain_pipeline();
    write_reg(REG_VP_SIZE, 26'h3FFFFFF);
    write_reg(REG_SCREEN_H, 13'h1FFF);
    write_reg(REG_VP_ORIGIN, 24'hFFF000);
    write_reg(REG_DEPTH_RANGE, 32'hFFFFFFFF);
    write_reg(REG_INDEX_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_vertex(32'sd65536, 32'sd65536, 32'sd65536);
    send_vertex(-32'sd65536, 32'sd12345, -32'sd65536);
    send_vertex(32'sd40000, -32'sd65536, 32'sd1);
    end_burst();
    drain_pipeline();
  endtask

  // one phase: random registers, then mostly in-volume vertices with noise
  task automatic run_phase(int unsigned n_items, bit persp, bit wild);
    logic [15:0] a [3];
    logic [15:0] cw;
    longint lim [3];
    longint zmag;
    logic [31:0] x, y, z;
    cw = $urandom_range(1, 16'h7FFF);
    for (int r = 0; r < 3; r++) begin
      a[r] = $urandom_range(1, 16'h7FFF);
      if ($urandom_range(0, 1)) a[r] = -a[r];
      lim[r] = (longint'(cw) * 65536) / longint'(signed'(a[r]) < 0 ? -signed'(a[r]) : a[r]);
    end
    if (wild) begin
      for (int r = 0; r < 4; r++) write_reg(r[3:0], {$urandom, $urandom});
    end else begin
      write_reg(REG_MATRIX_ROW0, pack_row(a[0], 16'd0, 16'd0, 16'd0));
      write_reg(REG_MATRIX_ROW1, pack_row(16'd0, a[1], 16'd0, 16'd0));
      write_reg(REG_MATRIX_ROW2, pack_row(16'd0, 16'd0, a[2], 16'd0));
      write_reg(REG_MATRIX_ROW3, persp ? pack_row(16'd0, 16'd0, -cw, 16'd0)
                                       : pack_row(16'd0, 16'd0, 16'd0, cw));
    end
    write_reg(REG_VP_ORIGIN, $urandom);
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_VP_SIZE, $urandom);
    else
      write_reg(REG_VP_SIZE, {13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096))});
    write_reg(REG_SCREEN_H, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 4096));
    write_reg(REG_DEPTH_RANGE, $urandom);
    for (int i = 0; i < n_items; i++) begin
      if (wild || $urandom_range(0, 4) == 0) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end else if (persp) begin
        // w = cw * |z|, so x and y scale with depth
        zmag = $urandom_range(1, 32'h7FFFFFFF);
        z = -zmag;
        x = coord_within((lim[0] * zmag) >>> 16);
        y = coord_within((lim[1] * zmag) >>> 16);
      end else begin
        x = coord_within(lim[0]);
        y = coord_within(lim[1]);
        z = coord_within(lim[2]);
      end
      send_vertex(x, y, z);
    end
    end_burst();
    drain_pipeline();
  endtask

  task automatic test_random_phases(int unsigned n_phases, int unsigned per_phase);
    for (int p = 0; p < n_phases; p++)
      run_phase(per_phase, $urandom_range(0, 1), $urandom_range(0, 7) == 0);
  endtask

  // receiver holds off long enough for the output buffer to fill
  task automatic test_output_holdoff();
    write_reg(REG_MATRIX_ROW0, RST_MATRIX_ROW0);
    write_reg(REG_MATRIX_ROW1, RST_MATRIX_ROW1);
    write_reg(REG_MATRIX_ROW2, RST_MATRIX_ROW2);
    write_reg(REG_MATRIX_ROW3, RST_MATRIX_ROW3);
    idle_en = 1'b0;
    hold_len = 400;
    hold_go = ~hold_go;
    for (int i = 0; i < 120; i++)
      send_vertex(coord_within(65536), coord_within(65536), coord_within(65536));
    end_burst();
    drain_pipeline();
    idle_en = 1'b1;
  endtask

  initial begin
    mat_row[0] = RST_MATRIX_ROW0;
    mat_row[1] = RST_MATRIX_ROW1;
    mat_row[2] = RST_MATRIX_ROW2;
    mat_row[3] = RST_MATRIX_ROW3;
    vp_origin = RST_VP_ORIGIN;
    vp_size = RST_VP_SIZE;
    scr_height = RST_SCREEN_H;
    z_range = RST_DEPTH_RANGE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_directed_corners();
    test_random_phases(8, 100);
    test_output_holdoff();
    test_random_phases(3, 100);
    // last stretch runs at full rate on both sides
    idle_en = 1'b0;
    test_random_phases(2, 150);

    drain_pipeline();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/vcp_pkg.sv
rtl/vcp_xform.sv
rtl/vcp_div.sv
rtl/vertex_clip_project_viewport.sv
tb/sv/vertex_clip_project_viewport_tb.sv
